### rtl/nernst_pkg.sv
// ----------------------------------------------------------------------------
// Nernst potential unit package
// Item types, codes, fixed widths and constants shared by the unit.
// ----------------------------------------------------------------------------
package nernst_pkg;

    // Default sizing of the concentration store and the log fraction
    localparam int CONC_BITS_DEF = 32;
    localparam int LOG_ITER_DEF  = 24;

    // Fixed field and register widths
    localparam int CONC_W   = 32;
    localparam int POT_W    = 32;
    localparam int TEMP_W   = 18;
    localparam int VAL_W    = 4;
    localparam int SCALE_W  = 24;
    localparam int CFG_W    = 24;
    localparam int MUL_W    = 32;

    // (R/F) * ln2 in unsigned Q0.40
    localparam int            K_W        = 26;
    localparam logic [K_W-1:0] RF_LN2_Q40 = 26'd65673283;

    // Gain datapath widths: |scale| * T, then times K, then drop 32 bits
    localparam int P1_W    = SCALE_W + TEMP_W;
    localparam int GACC_W  = P1_W + K_W;
    localparam int GMAG_W  = GACC_W - 32;

    // Register indexes
    localparam logic [1:0] REG_TEMPERATURE = 2'd0;
    localparam logic [1:0] REG_VALENCE     = 2'd1;
    localparam logic [1:0] REG_SCALE       = 2'd2;

    // Operation codes
    localparam logic [1:0] OP_SET_INSIDE  = 2'd0;
    localparam logic [1:0] OP_SET_OUTSIDE = 2'd1;
    localparam logic [1:0] OP_READ        = 2'd2;

    // Status codes
    localparam logic [1:0] STATUS_OK        = 2'd0;
    localparam logic [1:0] STATUS_UNDEFINED = 2'd1;
    localparam logic [1:0] STATUS_SATURATED = 2'd2;

    // Sequencer states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_GAIN,
        ST_GDIV,
        ST_NORM,
        ST_LOG,
        ST_DIFF,
        ST_PROD,
        ST_DONE
    } nernst_state_t;

    // Request item
    typedef struct packed {
        logic [1:0]        op;
        logic [CONC_W-1:0] conc;
    } nernst_req_t;

    // Response item
    typedef struct packed {
        logic signed [POT_W-1:0] potential;
        logic [1:0]              status;
    } nernst_rsp_t;

endpackage

### rtl/nernst_potential_unit_core.sv
// ----------------------------------------------------------------------------
// Nernst potential unit core
// Reversal potential from stored ion concentrations, one shared multiplier.
// ----------------------------------------------------------------------------
// Usage
//   req channel (req_valid/req_stall/req): an item carries op and conc. Op 0
//   replaces the inside concentration, op 1 the outside one, any other code
//   only asks for the potential. Items give one rsp each, bar a cfg abort.
//   rsp channel (rsp_valid/rsp_stall/rsp): potential in Q8.24 volts, status.
//   cfg port (cfg_write/cfg_index/cfg_data): temperature, valence, scale.
// Timing
//   A read-only item goes through the log difference, the product with the
//   gain and the response step. An item that sets a nonzero concentration
//   first runs a shift search that normalises the value, then the shared
//   32x32 multiplier squares the mantissa once per log bit. Only the changed
//   concentration has its log taken; both logs are kept. One item is in work
//   at a time; req_stall stays high until it finishes. Every effective cfg
//   write recomputes the gain in 5 gain steps and a bit-serial divide by
//   |valence| with req_stall high; an item before its last step gets no rsp.
// Reset and stall
//   Reset loads the default registers and runs the same gain pass.
//   A result waits in the rsp register while rsp_stall is high; the next item
//   is still taken and held in its last step until the register frees.
// ----------------------------------------------------------------------------
module nernst_potential_unit_core
    import nernst_pkg::*;
#(
    parameter int CONC_BITS      = CONC_BITS_DEF,
    parameter int LOG_ITERATIONS = LOG_ITER_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        req_valid,
    output logic        req_stall,
    input  nernst_req_t req,
    output logic        rsp_valid,
    input  logic        rsp_stall,
    output nernst_rsp_t rsp,
    input  logic        cfg_write,
    input  logic [1:0]  cfg_index,
    input  logic [CFG_W-1:0] cfg_data
);

    // Derived widths
    localparam int NSTEP   = $clog2(CONC_BITS);
    localparam int IW      = $clog2(CONC_BITS + 1);
    localparam int LOG_W   = IW + LOG_ITERATIONS;
    localparam int PROD_W  = LOG_W + GMAG_W;
    localparam int ACC_W   = (PROD_W > GACC_W) ? PROD_W : GACC_W;
    localparam int S_SHIFT = 8 + LOG_ITERATIONS;
    localparam int CNT_MAX = (GMAG_W > LOG_ITERATIONS) ? GMAG_W : LOG_ITERATIONS;
    localparam int CNT_W   = $clog2(CNT_MAX + 1);

    localparam logic [LOG_W-1:0] LOG_ONE_UNIT = LOG_W'(16) << LOG_ITERATIONS;

    // Control state
    nernst_state_t          state_reg, state_next;
    logic [CNT_W-1:0]       cnt_reg, cnt_next;
    logic [TEMP_W-1:0]      temp_reg, temp_next;
    logic [VAL_W-1:0]       val_reg, val_next;
    logic [SCALE_W-1:0]     scale_reg, scale_next;
    logic                   zero_in_reg, zero_in_next;
    logic                   zero_out_reg, zero_out_next;
    logic [LOG_W-1:0]       log_in_reg, log_in_next;
    logic [LOG_W-1:0]       log_out_reg, log_out_next;
    logic                   rsp_valid_reg, rsp_valid_next;

    // Datapath
    logic [2*MUL_W-1:0]     prod_reg, prod_next;
    logic [ACC_W-1:0]       acc_reg, acc_next;
    logic [P1_W-33:0]       p1_hi_reg, p1_hi_next;
    logic [GMAG_W-1:0]      gmag_reg, gmag_next;
    logic                   gneg_reg, gneg_next;
    logic [VAL_W-1:0]       rem_reg, rem_next;
    logic [CONC_BITS-1:0]   x_reg, x_next;
    logic [NSTEP-1:0]       sh_reg, sh_next;
    logic [IW-1:0]          p_reg, p_next;
    logic                   sel_out_reg, sel_out_next;
    logic [MUL_W-1:0]       m_reg, m_next;
    logic [LOG_ITERATIONS-1:0] frac_reg, frac_next;
    logic [LOG_W-1:0]       dmag_reg, dmag_next;
    logic                   neg_reg, neg_next;
    nernst_rsp_t            rsp_reg, rsp_next;

    // Shared multiplier
    logic [MUL_W-1:0]       mul_a, mul_b;
    logic [2*MUL_W-1:0]     mul_prod;

    // Scratch
    logic [SCALE_W-1:0]     smag;
    logic [VAL_W-1:0]       vmag;
    logic                   req_accept;
    logic [CONC_BITS-1:0]   conc_in;
    logic [VAL_W:0]         r_try;
    logic                   r_ge;
    logic [NSTEP-1:0]       step_k;
    logic [CONC_BITS-1:0]   top_mask;
    logic [CONC_BITS-1:0]   x_norm;
    logic [CONC_BITS+31:0]  x_ext;
    logic [MUL_W:0]         sq_t;
    logic [63:0]            dpad, gpad;
    logic [1:0]             pj, aj;
    logic [6:0]             shamt;
    logic [ACC_W-1:0]       mag;
    logic [POT_W-1:0]       limit;
    logic                   cfg_hit;

    assign mul_prod   = mul_a * mul_b;
    assign req_stall  = (state_reg != ST_IDLE) || cfg_write;
    assign req_accept = req_valid && !req_stall;
    assign rsp_valid  = rsp_valid_reg;
    assign rsp        = rsp_reg;

    assign smag = scale_reg[SCALE_W-1] ? (~scale_reg + SCALE_W'(1)) : scale_reg;
    assign vmag = val_reg[VAL_W-1] ? (~val_reg + VAL_W'(1)) : val_reg;
    assign conc_in = CONC_BITS'(req.conc);

    // Next state, sequencer and datapath steps
    always_comb
    begin
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        temp_next      = temp_reg;
        val_next       = val_reg;
        scale_next     = scale_reg;
        zero_in_next   = zero_in_reg;
        zero_out_next  = zero_out_reg;
        log_in_next    = log_in_reg;
        log_out_next   = log_out_reg;
        rsp_valid_next = rsp_valid_reg;
        prod_next      = mul_prod;
        acc_next       = acc_reg;
        p1_hi_next     = p1_hi_reg;
        gmag_next      = gmag_reg;
        gneg_next      = gneg_reg;
        rem_next       = rem_reg;
        x_next         = x_reg;
        sh_next        = sh_reg;
        p_next         = p_reg;
        sel_out_next   = sel_out_reg;
        m_next         = m_reg;
        frac_next      = frac_reg;
        dmag_next      = dmag_reg;
        neg_next       = neg_reg;
        rsp_next       = rsp_reg;
        mul_a          = '0;
        mul_b          = '0;
        r_try          = {rem_reg, gmag_reg[GMAG_W-1]};
        r_ge           = (r_try >= {1'b0, vmag});
        step_k         = NSTEP'(1) << (NSTEP'(NSTEP - 1) - NSTEP'(cnt_reg));
        top_mask       = ~({CONC_BITS{1'b1}} >> step_k);
        x_norm         = ((x_reg & top_mask) == '0) ? (x_reg << step_k) : x_reg;
        x_ext          = {x_norm, 32'b0};
        sq_t           = mul_prod[2*MUL_W-1:31];
        dpad           = 64'(dmag_reg);
        gpad           = 64'(gmag_reg);
        pj             = cnt_reg[1:0];
        aj             = cnt_reg[1:0] - 2'd1;
        shamt          = {aj[1] & aj[0], aj[1] ^ aj[0], 5'b0};
        mag            = acc_reg >> S_SHIFT;
        limit          = neg_reg ? 32'h8000_0000 : 32'h7FFF_FFFF;
        cfg_hit        = 1'b0;

        // Drop the response once taken
        if (rsp_valid_reg && !rsp_stall)
        begin
            rsp_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (req_accept)
                begin
                    cnt_next  = '0;
                    sh_next   = '0;
                    x_next    = conc_in;
                    state_next = ST_DIFF;
                    unique case (req.op)
                        OP_SET_INSIDE:
                        begin
                            zero_in_next = (conc_in == '0);
                            sel_out_next = 1'b0;
                            if (conc_in != '0)
                            begin
                                state_next = ST_NORM;
                            end
                        end
                        OP_SET_OUTSIDE:
                        begin
                            zero_out_next = (conc_in == '0);
                            sel_out_next  = 1'b1;
                            if (conc_in != '0)
                            begin
                                state_next = ST_NORM;
                            end
                        end
                        default:
                        begin
                            state_next = ST_DIFF;
                        end
                    endcase
                end
            end

            // Gain: |scale| * T, times K in two partial products
            ST_GAIN:
            begin
                cnt_next = cnt_reg + CNT_W'(1);
                unique case (cnt_reg)
                    CNT_W'(0):
                    begin
                        mul_a = MUL_W'(smag);
                        mul_b = MUL_W'(temp_reg);
                    end
                    CNT_W'(1):
                    begin
                        mul_a      = prod_reg[31:0];
                        mul_b      = MUL_W'(RF_LN2_Q40);
                        p1_hi_next = prod_reg[P1_W-1:32];
                    end
                    CNT_W'(2):
                    begin
                        mul_a    = MUL_W'(p1_hi_reg);
                        mul_b    = MUL_W'(RF_LN2_Q40);
                        acc_next = ACC_W'(prod_reg);
                    end
                    CNT_W'(3):
                    begin
                        acc_next = acc_reg + ACC_W'({{ACC_W{1'b0}}, prod_reg} << 32);
                    end
                    default:
                    begin
                        gmag_next  = acc_reg[32 +: GMAG_W];
                        gneg_next  = scale_reg[SCALE_W-1] ^ val_reg[VAL_W-1];
                        rem_next   = '0;
                        cnt_next   = '0;
                        state_next = ST_GDIV;
                    end
                endcase
            end

            // Restoring divide by |valence|, one quotient bit a cycle
            ST_GDIV:
            begin
                rem_next  = r_ge ? VAL_W'(r_try - {1'b0, vmag}) : VAL_W'(r_try);
                gmag_next = {gmag_reg[GMAG_W-2:0], r_ge};
                cnt_next  = cnt_reg + CNT_W'(1);
                if (cnt_reg == CNT_W'(GMAG_W - 1))
                begin
                    state_next = ST_IDLE;
                end
            end

            // Binary leading-one search, halving the shift each cycle
            ST_NORM:
            begin
                x_next   = x_norm;
                sh_next  = ((x_reg & top_mask) == '0) ? (sh_reg + step_k) : sh_reg;
                cnt_next = cnt_reg + CNT_W'(1);
                if (cnt_reg == CNT_W'(NSTEP - 1))
                begin
                    m_next     = x_ext[CONC_BITS+31 -: 32];
                    p_next     = IW'(CONC_BITS - 1) - IW'(sh_next);
                    frac_next  = '0;
                    cnt_next   = '0;
                    state_next = ST_LOG;
                end
            end

            // Square the mantissa, one fraction bit a cycle
            ST_LOG:
            begin
                mul_a     = m_reg;
                mul_b     = m_reg;
                m_next    = sq_t[MUL_W] ? sq_t[MUL_W:1] : sq_t[MUL_W-1:0];
                frac_next = {frac_reg[LOG_ITERATIONS-2:0], sq_t[MUL_W]};
                cnt_next  = cnt_reg + CNT_W'(1);
                if (cnt_reg == CNT_W'(LOG_ITERATIONS - 1))
                begin
                    if (sel_out_reg)
                    begin
                        log_out_next = {p_reg, frac_next};
                    end
                    else
                    begin
                        log_in_next = {p_reg, frac_next};
                    end
                    state_next = ST_DIFF;
                end
            end

            // Log difference magnitude and result sign
            ST_DIFF:
            begin
                cnt_next = '0;
                if (zero_in_reg || zero_out_reg)
                begin
                    state_next = ST_DONE;
                end
                else
                begin
                    if (log_out_reg < log_in_reg)
                    begin
                        dmag_next = log_in_reg - log_out_reg;
                        neg_next  = !gneg_reg;
                    end
                    else
                    begin
                        dmag_next = log_out_reg - log_in_reg;
                        neg_next  = gneg_reg;
                    end
                    state_next = ST_PROD;
                end
            end

            // Four 32x32 partial products, each added in the cycle after it forms
            ST_PROD:
            begin
                mul_a    = pj[1] ? dpad[63:32] : dpad[31:0];
                mul_b    = pj[0] ? gpad[63:32] : gpad[31:0];
                cnt_next = cnt_reg + CNT_W'(1);
                if (cnt_reg == '0)
                begin
                    acc_next = '0;
                end
                else
                begin
                    acc_next = acc_reg + ACC_W'({{ACC_W{1'b0}}, prod_reg} << shamt);
                end
                if (cnt_reg == CNT_W'(4))
                begin
                    state_next = ST_DONE;
                end
            end

            // Hold the result until the response register frees
            ST_DONE:
            begin
                if (!rsp_valid_reg || !rsp_stall)
                begin
                    if (zero_in_reg || zero_out_reg)
                    begin
                        rsp_next.potential = '0;
                        rsp_next.status    = STATUS_UNDEFINED;
                    end
                    else if (mag > ACC_W'(limit))
                    begin
                        rsp_next.potential = limit;
                        rsp_next.status    = STATUS_SATURATED;
                    end
                    else
                    begin
                        rsp_next.potential = neg_reg ? (POT_W'(0) - mag[POT_W-1:0])
                                                     : mag[POT_W-1:0];
                        rsp_next.status    = STATUS_OK;
                    end
                    rsp_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        // Register writes; a zero temperature or valence is ignored
        if (cfg_write)
        begin
            unique case (cfg_index)
                REG_TEMPERATURE:
                begin
                    if (cfg_data[TEMP_W-1:0] != '0)
                    begin
                        temp_next = cfg_data[TEMP_W-1:0];
                        cfg_hit   = 1'b1;
                    end
                end
                REG_VALENCE:
                begin
                    if (cfg_data[VAL_W-1:0] != '0)
                    begin
                        val_next = cfg_data[VAL_W-1:0];
                        cfg_hit  = 1'b1;
                    end
                end
                REG_SCALE:
                begin
                    scale_next = cfg_data[SCALE_W-1:0];
                    cfg_hit    = 1'b1;
                end
                default:
                begin
                    cfg_hit = 1'b0;
                end
            endcase
        end

        // Restart the gain pass after any effective write
        if (cfg_hit)
        begin
            state_next = ST_GAIN;
            cnt_next   = '0;
        end
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_GAIN;
            cnt_reg       <= '0;
            temp_reg      <= TEMP_W'(76800);
            val_reg       <= VAL_W'(1);
            scale_reg     <= SCALE_W'(65536);
            zero_in_reg   <= 1'b0;
            zero_out_reg  <= 1'b0;
            log_in_reg    <= LOG_ONE_UNIT;
            log_out_reg   <= LOG_ONE_UNIT;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            temp_reg      <= temp_next;
            val_reg       <= val_next;
            scale_reg     <= scale_next;
            zero_in_reg   <= zero_in_next;
            zero_out_reg  <= zero_out_next;
            log_in_reg    <= log_in_next;
            log_out_reg   <= log_out_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    // Datapath registers
    always_ff @(posedge clk)
    begin
        prod_reg    <= prod_next;
        acc_reg     <= acc_next;
        p1_hi_reg   <= p1_hi_next;
        gmag_reg    <= gmag_next;
        gneg_reg    <= gneg_next;
        rem_reg     <= rem_next;
        x_reg       <= x_next;
        sh_reg      <= sh_next;
        p_reg       <= p_next;
        sel_out_reg <= sel_out_next;
        m_reg       <= m_next;
        frac_reg    <= frac_next;
        dmag_reg    <= dmag_next;
        neg_reg     <= neg_next;
        rsp_reg     <= rsp_next;
    end

endmodule
